// ===== rtl/buzzer_alert_pattern_sequencer_top_macros.svh =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer assertion macros
// Shared concurrent assertion forms for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef BUZZER_ALERT_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define BUZZER_ALERT_PATTERN_SEQUENCER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BAPSEQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bapseq assertion failed");

// Next-cycle implication, disabled during reset.
`define BAPSEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bapseq assertion failed");

`endif

// ===== rtl/bapseq_pkg.sv =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer package
// Operation and pattern codes, register map, word types and small helpers.
// ----------------------------------------------------------------------------
package bapseq_pkg;

   localparam int ADDR_BITS = 4;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_SET     = 2'd1;
   localparam logic [1:0] OP_ONESHOT = 2'd2;

   localparam logic [2:0] PAT_NONE     = 3'd0;
   localparam logic [2:0] PAT_REMINDER = 3'd1;
   localparam logic [2:0] PAT_SUCCESS  = 3'd2;
   localparam logic [2:0] PAT_WARNING  = 3'd3;
   localparam logic [2:0] PAT_CLICK    = 3'd4;

   localparam logic [1:0] REG_BEEP_ON  = 2'd0;
   localparam logic [1:0] REG_BEEP_OFF = 2'd1;
   localparam logic [1:0] REG_PERIOD   = 2'd2;
   localparam logic [1:0] REG_POLARITY = 2'd3;

   localparam logic [15:0] BEEP_ON_RESET  = 16'd100;
   localparam logic [15:0] BEEP_OFF_RESET = 16'd100;
   localparam logic [23:0] PERIOD_RESET   = 24'd5000;
   localparam logic        POLARITY_RESET = 1'b1;

   typedef struct packed {
      logic [1:0] op;
      logic [2:0] pattern;
   } req_type;

   typedef struct packed {
      logic       buzzer_sounding;
      logic       pin_level;
      logic [2:0] playing_pattern;
      logic [2:0] standing_pattern;
   } rsp_type;

   typedef struct packed {
      logic [15:0] on_ticks;
      logic [15:0] gap_ticks;
      logic [23:0] repeat_period_ms;
      logic        pin_active_high;
   } cfg_type;

   function automatic logic [2:0] clean_pattern(input logic [2:0] p);
      logic [2:0] r;
      r = (p > PAT_CLICK) ? PAT_NONE : p;
      return r;
   endfunction

   function automatic logic [1:0] beep_count(input logic [2:0] p);
      logic [1:0] r;
      case (p)
         PAT_REMINDER: r = 2'd2;
         PAT_SUCCESS:  r = 2'd1;
         PAT_WARNING:  r = 2'd3;
         PAT_CLICK:    r = 2'd1;
         default:      r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/buzzer_alert_pattern_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer top level
// Tick-driven beep burst generator with standing and one-shot patterns.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one word per operation (1 ms tick, set standing pattern,
//   play one-shot). rsp channel: exactly one word per req word, giving the
//   buzzer drive, pin level, playing pattern and standing pattern after it.
//   The APB-style port sets beep on/off time, repeat period and polarity;
//   write it only while no word is in flight.
//   Path: a req word accepted sits in the input register, and its rsp
//   word is loaded into the result register. Throughput is one word per
//   cycle while the receiver does not stall: the state update is a few
//   counter increments and compares between the input and result registers.
//   When the receiver stalls, the result register holds its word and the
//   input register holds one more; req_ready drops only once both are full.
//   Reset clears both pipeline registers and all pattern state to none and
//   loads the register defaults (100, 100, 5000, active high).
// ----------------------------------------------------------------------------
`include "buzzer_alert_pattern_sequencer_top_macros.svh"

module buzzer_alert_pattern_sequencer_top #(
   parameter int TIME_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bapseq_pkg::req_type              req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bapseq_pkg::rsp_type              rsp_payload,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bapseq_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   localparam int CMP_BITS = (TIME_BITS > 24) ? TIME_BITS : 24;

   bapseq_pkg::cfg_type cfg;

   bapseq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // pipeline registers
   logic                in_valid_ff, in_valid_in;
   bapseq_pkg::req_type in_ff;
   logic                out_valid_ff, out_valid_in;
   bapseq_pkg::rsp_type out_ff, out_in;
   logic                advance;
   logic                step;

   // sequencer state
   logic [2:0]           standing_ff, standing_in;
   logic [2:0]           pending_ff, pending_in;
   logic [2:0]           playing_ff, playing_in;
   logic [1:0]           beeps_left_ff, beeps_left_in;
   logic                 sounding_ff, sounding_in;
   logic [TIME_BITS-1:0] phase_ff, phase_in;
   logic [TIME_BITS-1:0] cycle_ff, cycle_in;

   logic [TIME_BITS-1:0] phase_inc, cycle_inc;
   logic [17:0]          on_limit;
   logic [CMP_BITS-1:0]  phase_limit;
   logic                 phase_done;
   logic                 period_done;
   logic [2:0]           pat;
   logic                 start;
   logic [2:0]           start_pat;

   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign step      = in_valid_ff && advance;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   // saturating elapsed counters
   assign phase_inc = (phase_ff == '1) ? phase_ff : phase_ff + TIME_BITS'(1);
   assign cycle_inc = (cycle_ff == '1) ? cycle_ff : cycle_ff + TIME_BITS'(1);

   always_comb begin
      case (playing_ff)
         bapseq_pkg::PAT_SUCCESS: on_limit = {1'b0, cfg.on_ticks, 1'b0}
                                            + {2'b00, cfg.on_ticks};
         bapseq_pkg::PAT_CLICK:   on_limit = {3'b000, cfg.on_ticks[15:1]};
         default:                 on_limit = {2'b00, cfg.on_ticks};
      endcase
   end

   assign phase_limit = sounding_ff ? CMP_BITS'(on_limit) : CMP_BITS'(cfg.gap_ticks);
   assign phase_done  = CMP_BITS'(phase_inc) >= phase_limit;
   assign period_done = CMP_BITS'(cycle_inc) >= CMP_BITS'(cfg.repeat_period_ms);

   assign pat = bapseq_pkg::clean_pattern(in_ff.pattern);

   always_comb begin
      standing_in   = standing_ff;
      pending_in    = pending_ff;
      playing_in    = playing_ff;
      beeps_left_in = beeps_left_ff;
      sounding_in   = sounding_ff;
      phase_in      = phase_ff;
      cycle_in      = cycle_ff;
      start         = 1'b0;
      start_pat     = bapseq_pkg::PAT_NONE;
      case (in_ff.op)
         bapseq_pkg::OP_TICK: begin
            phase_in = phase_inc;
            cycle_in = cycle_inc;
            if (beeps_left_ff != 2'd0) begin
               if (phase_done) begin
                  // toggle between on phase and off gap
                  if (sounding_ff) begin
                     sounding_in   = 1'b0;
                     beeps_left_in = beeps_left_ff - 2'd1;
                  end else begin
                     sounding_in = 1'b1;
                  end
                  phase_in = '0;
               end
            end else begin
               sounding_in = 1'b0;
               if (pending_ff != bapseq_pkg::PAT_NONE) begin
                  // one-shot done: fall back to the standing pattern
                  pending_in = bapseq_pkg::PAT_NONE;
                  if (standing_ff != bapseq_pkg::PAT_NONE) begin
                     start     = 1'b1;
                     start_pat = standing_ff;
                  end else begin
                     playing_in = bapseq_pkg::PAT_NONE;
                  end
               end else if (standing_ff == bapseq_pkg::PAT_REMINDER && period_done) begin
                  start     = 1'b1;
                  start_pat = bapseq_pkg::PAT_REMINDER;
               end else if (standing_ff == bapseq_pkg::PAT_SUCCESS ||
                            standing_ff == bapseq_pkg::PAT_WARNING) begin
                  standing_in = bapseq_pkg::PAT_NONE;
               end
            end
         end
         bapseq_pkg::OP_SET: begin
            if (standing_ff != pat) begin
               standing_in = pat;
               // apply at once only when nothing is playing
               if (beeps_left_ff == 2'd0 && pending_ff == bapseq_pkg::PAT_NONE) begin
                  if (pat == bapseq_pkg::PAT_NONE) begin
                     sounding_in = 1'b0;
                     playing_in  = bapseq_pkg::PAT_NONE;
                  end else begin
                     start     = 1'b1;
                     start_pat = pat;
                  end
               end
            end
         end
         bapseq_pkg::OP_ONESHOT: begin
            pending_in = pat;
            start      = 1'b1;
            start_pat  = pat;
         end
         default: ;
      endcase
      if (start) begin
         playing_in    = start_pat;
         beeps_left_in = bapseq_pkg::beep_count(start_pat);
         phase_in      = '0;
         cycle_in      = '0;
         sounding_in   = bapseq_pkg::beep_count(start_pat) != 2'd0;
      end
   end

   always_comb begin
      out_in.buzzer_sounding  = sounding_in;
      out_in.pin_level        = ~(sounding_in ^ cfg.pin_active_high);
      out_in.playing_pattern  = playing_in;
      out_in.standing_pattern = standing_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         standing_ff   <= bapseq_pkg::PAT_NONE;
         pending_ff    <= bapseq_pkg::PAT_NONE;
         playing_ff    <= bapseq_pkg::PAT_NONE;
         beeps_left_ff <= 2'd0;
         sounding_ff   <= 1'b0;
         phase_ff      <= '0;
         cycle_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            standing_ff   <= standing_in;
            pending_ff    <= pending_in;
            playing_ff    <= playing_in;
            beeps_left_ff <= beeps_left_in;
            sounding_ff   <= sounding_in;
            phase_ff      <= phase_in;
            cycle_ff      <= cycle_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         in_ff <= req_payload;
      end
      if (step) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   `BAPSEQ_ASSERT_NOW(a_silent_without_beeps, clock, reset,
      beeps_left_ff == 2'd0, !sounding_ff)
   `BAPSEQ_ASSERT_NOW(a_oneshot_is_playing, clock, reset,
      pending_ff != bapseq_pkg::PAT_NONE, playing_ff == pending_ff)
   `BAPSEQ_ASSERT_NEXT(a_stall_holds_state, clock, reset,
      out_valid_ff && !rsp_ready,
      $stable(standing_ff) && $stable(beeps_left_ff) && $stable(phase_ff))
   `BAPSEQ_ASSERT_NEXT(a_stall_keeps_input, clock, reset,
      in_valid_ff && !advance, in_valid_ff && $stable(in_ff))

endmodule

// ===== rtl/bapseq_csr.sv =====
// ----------------------------------------------------------------------------
// Buzzer pattern sequencer register block
// APB-style register file holding beep timing, repeat period and polarity.
// ----------------------------------------------------------------------------
module bapseq_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bapseq_pkg::ADDR_BITS-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output bapseq_pkg::cfg_type             cfg
);

   bapseq_pkg::cfg_type cfg_ff;
   bapseq_pkg::cfg_type cfg_in;
   logic [1:0]          reg_index;
   logic                wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_en     = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            bapseq_pkg::REG_BEEP_ON:  cfg_in.on_ticks         = pwdata[15:0];
            bapseq_pkg::REG_BEEP_OFF: cfg_in.gap_ticks        = pwdata[15:0];
            bapseq_pkg::REG_PERIOD:   cfg_in.repeat_period_ms = pwdata[23:0];
            bapseq_pkg::REG_POLARITY: cfg_in.pin_active_high  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         bapseq_pkg::REG_BEEP_ON:  prdata = {16'd0, cfg_ff.on_ticks};
         bapseq_pkg::REG_BEEP_OFF: prdata = {16'd0, cfg_ff.gap_ticks};
         bapseq_pkg::REG_PERIOD:   prdata = {8'd0, cfg_ff.repeat_period_ms};
         bapseq_pkg::REG_POLARITY: prdata = {31'd0, cfg_ff.pin_active_high};
         default:                  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_ticks         <= bapseq_pkg::BEEP_ON_RESET;
         cfg_ff.gap_ticks        <= bapseq_pkg::BEEP_OFF_RESET;
         cfg_ff.repeat_period_ms <= bapseq_pkg::PERIOD_RESET;
         cfg_ff.pin_active_high  <= bapseq_pkg::POLARITY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
